// ===== sv/spd_pkg.sv =====
// stationary presence detector package
// widths, register indexes and reset values shared by the detector rtl
package spd_pkg;

  localparam int SampleW = 16;
  localparam int SumW = 18;
  localparam int StillW = 13;
  localparam int StageW = 4;
  localparam int AvgTaps = 4;
  localparam int DelayDepth = AvgTaps - 1;

  localparam int InDataW = 16;
  localparam int OutDataW = 40;
  localparam int AddrW = 4;
  localparam int ApbDataW = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_NEAR_LIMIT = 2'd0;
  localparam logic [1:0] REG_STILL_LIMIT = 2'd1;
  localparam logic [1:0] REG_DWELL_COUNT = 2'd2;

  localparam logic [SampleW-1:0] NEAR_LIMIT_RESET = 16'd1200;
  localparam logic [StillW-1:0] STILL_LIMIT_RESET = 13'd10;
  localparam logic [StageW-1:0] DWELL_COUNT_RESET = 4'd3;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [SumW-1:0] sum_t;

  typedef struct packed {
    sum_t average_qmm;
    sum_t speed_emm;
    logic present;
  } result_t;

endpackage

// ===== sv/stationary_presence_detector.sv =====
// stationary presence detector top level
// a result is registered in the output register, or in the skid slot while the output is stalled
// throughput: one item per cycle while the skid slot is empty; the adder tree, one subtract
// and two compares sit between the input transfer and the result register
// reset: rst (synchronous) clears delay lines, dwell stage and output valid,
// and restores the register reset values; no clearing pass
module stationary_presence_detector
  import spd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // [15:0] range_mm
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // [17:0] average_qmm, [35:18] speed_emm,
                                         // [36] present, [39:37] zero
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  sample_t              near_limit_mm;
  logic [StillW-1:0]    still_limit_mm;
  logic [StageW-1:0]    dwell_count;

  sample_t              sample_delay [DelayDepth];
  sum_t                 sum_delay [DelayDepth];
  logic [StageW-1:0]    dwell_stage;
  logic [StageW-1:0]    dwell_stage_next;

  result_t              out_data;
  result_t              skid_data;
  logic                 skid_valid;
  result_t              result;

  logic                 accept;
  logic                 cfg_write;
  logic [1:0]           reg_index;
  sample_t              sample;
  sum_t                 sum;
  sum_t                 old_sum;
  sum_t                 speed;
  logic                 is_near;
  logic                 is_still;
  logic                 dwell_done;
  logic                 present;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit_mm  <= NEAR_LIMIT_RESET;
      still_limit_mm <= STILL_LIMIT_RESET;
      dwell_count    <= DWELL_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_NEAR_LIMIT:  near_limit_mm  <= pwdata[SampleW-1:0];
        REG_STILL_LIMIT: still_limit_mm <= pwdata[StillW-1:0];
        REG_DWELL_COUNT: dwell_count    <= pwdata[StageW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_NEAR_LIMIT:  prdata = {{(ApbDataW-SampleW){1'b0}}, near_limit_mm};
      REG_STILL_LIMIT: prdata = {{(ApbDataW-StillW){1'b0}}, still_limit_mm};
      REG_DWELL_COUNT: prdata = {{(ApbDataW-StageW){1'b0}}, dwell_count};
      default:         prdata = '0;
    endcase
  end

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign sample   = s_tdata[SampleW-1:0];

  // four-tap sum is the average in quarter millimetres
  assign sum = SumW'(sample) + SumW'(sample_delay[0]) + SumW'(sample_delay[1])
             + SumW'(sample_delay[2]);
  assign old_sum = sum_delay[DelayDepth-1];
  assign speed   = (sum >= old_sum) ? (sum - old_sum) : (old_sum - sum);

  assign is_near    = sum < {near_limit_mm, 2'b00};
  assign is_still   = speed < SumW'({still_limit_mm, 3'b000});
  assign dwell_done = ({1'b0, dwell_stage} + 5'd1) >= {1'b0, dwell_count};

  always_comb begin
    dwell_stage_next = dwell_stage;
    present          = 1'b0;
    if (is_near) begin
      if (!is_still) begin
        dwell_stage_next = '0;
      end else if (dwell_done) begin
        dwell_stage_next = '0;
        present          = 1'b1;
      end else begin
        dwell_stage_next = dwell_stage + 4'd1;
      end
    end
  end

  assign result.average_qmm = sum;
  assign result.speed_emm   = speed;
  assign result.present     = present;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DelayDepth; k++) begin
        sample_delay[k] <= '0;
        sum_delay[k]    <= '0;
      end
      dwell_stage <= '0;
    end else if (accept) begin
      sample_delay[0] <= sample;
      sum_delay[0]    <= sum;
      for (int k = 1; k < DelayDepth; k++) begin
        sample_delay[k] <= sample_delay[k-1];
        sum_delay[k]    <= sum_delay[k-1];
      end
      dwell_stage <= dwell_stage_next;
    end
  end

  // output register with one skid slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

  assign m_tdata = {{(OutDataW-2*SumW-1){1'b0}}, out_data.present,
                    out_data.speed_emm, out_data.average_qmm};

endmodule

// ===== sim/stationary_presence_detector_test.sv =====
`timescale 1ns / 100ps
// testbench for stationary_presence_detector: range samples in, average, speed and present out
// depends on spd_pkg and the detector rtl; a scoreboard class predicts every result
module stationary_presence_detector_test;
  import spd_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int HoldCycles = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;   // [15:0] range_mm
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;       // [17:0] average_qmm, [35:18] speed_emm, [36] present
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int hold_left = 0;

  class presence_board;
    logic [SampleW-1:0] near_mm;
    logic [StillW-1:0] still_mm;
    logic [StageW-1:0] dwell_target;
    sample_t ranges[DelayDepth];
    sum_t sums[DelayDepth];
    logic [StageW-1:0] stage;
    result_t expected_readings[$];
    int errors;

    function new();
      near_mm = NEAR_LIMIT_RESET;
      still_mm = STILL_LIMIT_RESET;
      dwell_target = DWELL_COUNT_RESET;
      foreach (ranges[k]) begin
        ranges[k] = '0;
        sums[k] = '0;
      end
      stage = '0;
      errors = 0;
    endfunction

    function void load_setting(logic [1:0] idx, logic [ApbDataW-1:0] word);
      case (idx)
        REG_NEAR_LIMIT: near_mm = word[SampleW-1:0];
        REG_STILL_LIMIT: still_mm = word[StillW-1:0];
        REG_DWELL_COUNT: dwell_target = word[StageW-1:0];
        default: ;
      endcase
    endfunction

    // work out the result of one accepted range sample and queue it
    function void note_range(sample_t range_mm);
      result_t want;
      int total;
      int back;
      int speed;
      total = int'(range_mm) + int'(ranges[0]) + int'(ranges[1]) + int'(ranges[2]);
      back = int'(sums[2]);
      speed = (total >= back) ? total - back : back - total;
      ranges[2] = ranges[1];
      ranges[1] = ranges[0];
      ranges[0] = range_mm;
      sums[2] = sums[1];
      sums[1] = sums[0];
      sums[0] = total[SumW-1:0];
      want.average_qmm = total[SumW-1:0];
      want.speed_emm = speed[SumW-1:0];
      want.present = 1'b0;
      if (total < AvgTaps * int'(near_mm)) begin
        if (speed < 2 * AvgTaps * int'(still_mm)) begin
          // a target of zero behaves like one
          if (int'(stage) + 1 >= int'(dwell_target)) begin
            want.present = 1'b1;
            stage = '0;
          end else begin
            stage = stage + 1'b1;
          end
        end else begin
          stage = '0;
        end
      end
      expected_readings.push_back(want);
    endfunction

    function void flag(string what, int want, int got);
      errors++;
      if (errors <= 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void check_reading(logic [OutDataW-1:0] data);
      result_t want;
      if (expected_readings.size() == 0) begin
        flag("result with nothing pending, average_qmm", -1, int'(data[SumW-1:0]));
        return;
      end
      want = expected_readings.pop_front();
      if (data[SumW-1:0] !== want.average_qmm)
        flag("average_qmm", int'(want.average_qmm), int'(data[SumW-1:0]));
      if (data[2*SumW-1:SumW] !== want.speed_emm)
        flag("speed_emm", int'(want.speed_emm), int'(data[2*SumW-1:SumW]));
      if (data[2*SumW] !== want.present)
        flag("present", int'(want.present), int'(data[2*SumW]));
      if (data[OutDataW-1:2*SumW+1] !== '0)
        flag("tdata padding", 0, int'(data[OutDataW-1:2*SumW+1]));
    endfunction
  endclass

  presence_board sb;

  stationary_presence_detector u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off whenever hold_req toggles
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reading(m_tdata);
  end

  function automatic sample_t clip_mm(input int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[SampleW-1:0];
  endfunction

  task automatic send_range(input sample_t range_mm);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= range_mm;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_range(range_mm);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_readings.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // setup cycle then access cycle; psel is lowered by the caller after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [ApbDataW-1:0] word);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.load_setting(idx, word);
  endtask

  task automatic configure(input int near, input int still, input int dwell);
    logic [ApbDataW-1:0] word;
    drain();
    word = $urandom();
    word[SampleW-1:0] = near[SampleW-1:0];
    write_reg(REG_NEAR_LIMIT, word);
    word = $urandom();
    word[StillW-1:0] = still[StillW-1:0];
    write_reg(REG_STILL_LIMIT, word);
    word = $urandom();
    word[StageW-1:0] = dwell[StageW-1:0];
    write_reg(REG_DWELL_COUNT, word);
    write_reg(REG_UNUSED, $urandom());
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_directed();
    int k;
    // zeros after reset qualify at once and reach the default dwell of three
    for (k = 0; k < 3; k++) send_range('0);
    // a step to 1000 mm: moving at first, then still
    for (k = 0; k < 8; k++) send_range(16'd1000);
    // far: stage holds
    for (k = 0; k < 2; k++) send_range(16'd2000);
    for (k = 0; k < 4; k++) send_range('1);
    for (k = 0; k < 4; k++) send_range('0);
    // dwell target lowered below the stage reached so far
    configure(65535, 8191, 15);
    for (k = 0; k < 5; k++) send_range(16'd100);
    configure(65535, 8191, 2);
    send_range(16'd100);
    // dwell target of zero
    configure(65535, 8191, 0);
    send_range(16'd100);
    send_range(16'd101);
  endtask

  // mostly steady runs around a base distance, with noise and extreme samples between
  task automatic run_random(input int count);
    int sent;
    int pick;
    int lim;
    int base;
    int spread;
    int len;
    int k;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        lim = 2 * int'(sb.near_mm) + 200;
        if (lim > 65535) lim = 65535;
        base = int'($urandom_range(lim));
        if ($urandom_range(9) < 7) spread = int'($urandom_range(int'(sb.still_mm) / 2 + 1));
        else spread = int'($urandom_range(int'(sb.still_mm) * 4 + 50));
        len = int'($urandom_range(20, 4));
        for (k = 0; k < len; k++)
          send_range(clip_mm(base + int'($urandom_range(2 * spread)) - spread));
        sent += len;
      end else if (pick < 90) begin
        send_range(sample_t'($urandom_range(65535)));
        sent++;
      end else begin
        send_range(pick[0] ? '1 : '0);
        sent++;
      end
    end
  endtask

  initial begin
    int mode;
    int half;
    int phase;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 58; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 58; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      for (half = 0; half < 2; half++) begin
        phase = mode * 2 + half;
        if (phase == 0) configure(65535, 8191, 1);
        else if (phase == 1) configure(0, 0, 15);
        else if (phase == 7) configure(NEAR_LIMIT_RESET, STILL_LIMIT_RESET, DWELL_COUNT_RESET);
        else configure(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(3000, 200),
                       ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(40),
                       $urandom_range(15));
        // long receiver hold-off while the sender keeps offering
        if (phase == 2) hold_req <= ~hold_req;
        run_random(200);
      end
    end
    drain();
    if (sb.errors == 0 && sb.expected_readings.size() == 0) begin
      $display("stationary_presence_detector_test: clean");
    end else begin
      $display("stationary_presence_detector_test: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("stationary_presence_detector_test: errors");
    $finish;
  end

endmodule
